// ===== rtl/rgbc_pkg.sv =====
// Shared types, constants and helper functions for the RGB convolution block.
package rgbc_pkg;

  // Default sizes of the block.
  localparam int DEF_MAX_WIDTH      = 1024;
  localparam int DEF_MAX_HEIGHT     = 1024;
  localparam int DEF_MAX_KERNEL     = 5;
  localparam int DEF_COEF_FRAC_BITS = 10;

  // Pixel and coefficient formats.
  localparam int PIX_W   = 8;
  localparam int COLORS  = 3;
  localparam int PIXEL_W = PIX_W * COLORS;
  localparam int COEF_W  = 12;
  localparam int KROWS   = 5;
  localparam int KTAPS   = 5;
  localparam int KROW_W  = COEF_W * KTAPS;
  localparam int PROD_W  = COEF_W + PIX_W + 1;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // Configuration port.
  localparam int KSIZE_W    = 3;
  localparam int DIM_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = KROW_W;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROW0  = 3'd3;

  // Reset values of the geometry registers.
  localparam int RST_KERNEL_SIZE = 1;
  localparam int RST_IMAGE_DIM   = 1024;

  typedef logic [KROWS-1:0][KROW_W-1:0] kernel_t;

  // Control that travels with a pixel through the pipeline.
  typedef struct packed {
    logic valid;
    logic last;
  } stage_t;

  // Width of an index into a set of v entries, at least one bit.
  function automatic int clog2m(int v);
    int r;
    r = $clog2(v);
    return (r < 1) ? 1 : r;
  endfunction

  // Clamp a register value into 1..hi.
  function automatic int sat_val(int v, int hi);
    int r;
    r = v;
    if (r < 1) r = 1;
    if (r > hi) r = hi;
    return r;
  endfunction

  // Coefficient of tap (i, j); taps outside the KROWS x KTAPS store are zero.
  function automatic logic signed [COEF_W-1:0] coef_at(kernel_t k, int i, int j);
    logic signed [COEF_W-1:0] c;
    c = '0;
    if (i < KROWS && j < KTAPS) begin
      c = k[i][COEF_W*j +: COEF_W];
    end
    return c;
  endfunction

endpackage

// ===== rtl/rgbc_ram.sv =====
// Generic simple dual-port RAM with a registered, read-first read port.
module rgbc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [rgbc_pkg::clog2m(DEPTH)-1:0]  waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic                                re,
  input  logic [rgbc_pkg::clog2m(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]                    rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // A read and a write of the same entry in one cycle return the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== rtl/rgbc_ctrl.sv =====
// Configuration registers, raster counters and the emit decision.
module rgbc_ctrl #(
  parameter int MAX_WIDTH  = rgbc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rgbc_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_KERNEL = rgbc_pkg::DEF_MAX_KERNEL,
  localparam int NB = MAX_KERNEL,
  localparam int BW = rgbc_pkg::clog2m(NB),
  localparam int AW = rgbc_pkg::clog2m((MAX_WIDTH + NB - 1) / NB),
  localparam int NW = $clog2(MAX_KERNEL + 1),
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1),
  localparam int CW = rgbc_pkg::clog2m(MAX_WIDTH),
  localparam int RW = rgbc_pkg::clog2m(MAX_HEIGHT)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rgbc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rgbc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rgbc_pkg::PIX_W-1:0]        red,
  input  logic [rgbc_pkg::PIX_W-1:0]        green,
  input  logic [rgbc_pkg::PIX_W-1:0]        blue,
  input  logic                              drain,
  input  logic                              en1,
  output logic [NW-1:0]                     n_sat,
  output logic [NW-1:0]                     half,
  output logic [WW-1:0]                     w_sat,
  output logic [HW-1:0]                     h_sat,
  output rgbc_pkg::kernel_t                 kernel,
  output logic                              wr_en,
  output logic [BW-1:0]                     wr_rb,
  output logic [BW-1:0]                     wr_cb,
  output logic [AW-1:0]                     wr_ca,
  output logic [rgbc_pkg::PIXEL_W-1:0]      wr_data,
  output rgbc_pkg::stage_t                  s1,
  output logic [RW-1:0]                     s1_row,
  output logic [CW-1:0]                     s1_col,
  output logic [BW-1:0]                     s1_rb,
  output logic [BW-1:0]                     s1_cb,
  output logic [AW-1:0]                     s1_ca
);
  import rgbc_pkg::*;

  localparam int TW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int DW = $clog2(MAX_KERNEL * (MAX_WIDTH + 1) + 1);
  localparam int MW = ((TW > DW) ? TW : DW) + 1;
  localparam int N0 = sat_val(RST_KERNEL_SIZE, MAX_KERNEL);
  localparam int W0 = sat_val(RST_IMAGE_DIM, MAX_WIDTH);
  localparam int H0 = sat_val(RST_IMAGE_DIM, MAX_HEIGHT);
  localparam int R0 = N0 - 1 - N0 / 2;

  logic [KSIZE_W-1:0] ksize;
  logic [DIM_W-1:0]   img_w;
  logic [DIM_W-1:0]   img_h;
  logic               settle;
  logic               geo_wr;

  logic [TW-1:0] total;
  logic [DW-1:0] delay;
  logic [NW-1:0] n_next;
  logic [NW-1:0] half_next;
  logic [WW-1:0] w_next;
  logic [HW-1:0] h_next;
  logic [TW-1:0] total_next;
  logic [DW-1:0] delay_next;

  logic [TW-1:0] rx;
  logic [TW-1:0] em;
  logic [CW-1:0] wcol;
  logic [BW-1:0] wrb;
  logic [BW-1:0] wcb;
  logic [AW-1:0] wca;
  logic [RW-1:0] orow;
  logic [CW-1:0] ocol;
  logic [BW-1:0] orb;
  logic [BW-1:0] ocb;
  logic [AW-1:0] oca;

  logic acc;
  logic complete;
  logic pix;
  logic more;
  logic emit;
  logic last;

  assign cfg_ready = 1'b1;
  assign geo_wr = cfg_valid && (cfg_index == REG_KERNEL_SIZE ||
                                cfg_index == REG_IMAGE_WIDTH ||
                                cfg_index == REG_IMAGE_HEIGHT);

  // Register writes; input is held off in the cycle after each write.
  always_ff @(posedge clk) begin
    if (rst) begin
      ksize  <= KSIZE_W'(RST_KERNEL_SIZE);
      img_w  <= DIM_W'(RST_IMAGE_DIM);
      img_h  <= DIM_W'(RST_IMAGE_DIM);
      kernel <= '0;
      settle <= 1'b0;
    end else begin
      settle <= cfg_valid;
      if (cfg_valid) begin
        case (cfg_index)
          REG_KERNEL_SIZE:  ksize <= cfg_data[KSIZE_W-1:0];
          REG_IMAGE_WIDTH:  img_w <= cfg_data[DIM_W-1:0];
          REG_IMAGE_HEIGHT: img_h <= cfg_data[DIM_W-1:0];
          default:          kernel[cfg_index - REG_KERNEL_ROW0] <= cfg_data;
        endcase
      end
    end
  end

  // Clamped geometry and the figures derived from it.
  always_comb begin
    int n_i;
    int w_i;
    int h_i;
    int r_i;
    n_i = sat_val(int'(ksize), MAX_KERNEL);
    w_i = sat_val(int'(img_w), MAX_WIDTH);
    h_i = sat_val(int'(img_h), MAX_HEIGHT);
    r_i = n_i - 1 - n_i / 2;
    n_next     = NW'(n_i);
    half_next  = NW'(n_i / 2);
    w_next     = WW'(w_i);
    h_next     = HW'(h_i);
    total_next = TW'(w_i * h_i);
    delay_next = DW'(r_i * (w_i + 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_sat <= NW'(N0);
      half  <= NW'(N0 / 2);
      w_sat <= WW'(W0);
      h_sat <= HW'(H0);
      total <= TW'(W0 * H0);
      delay <= DW'(R0 * (W0 + 1));
    end else begin
      n_sat <= n_next;
      half  <= half_next;
      w_sat <= w_next;
      h_sat <= h_next;
      total <= total_next;
      delay <= delay_next;
    end
  end

  // Emit decision: a pixel emits once enough of the image is in,
  // a drain emits only after the whole image is in.
  assign in_ready = (!s1.valid || en1) && !settle;
  assign acc      = in_valid && in_ready;
  assign complete = (rx == total);
  assign pix      = acc && !drain && !complete;
  assign more     = (em < total);
  assign last     = (em + TW'(1) == total);

  always_comb begin
    if (pix) begin
      emit = more && (MW'(rx) >= MW'(em) + MW'(delay));
    end else begin
      emit = acc && complete && more;
    end
  end

  assign wr_en   = pix;
  assign wr_rb   = wrb;
  assign wr_cb   = wcb;
  assign wr_ca   = wca;
  assign wr_data = {red, green, blue};

  // Raster counters for the write side and the output side.
  always_ff @(posedge clk) begin
    if (rst || geo_wr || (emit && last)) begin
      rx   <= '0;
      em   <= '0;
      wcol <= '0;
      wrb  <= '0;
      wcb  <= '0;
      wca  <= '0;
      orow <= '0;
      ocol <= '0;
      orb  <= '0;
      ocb  <= '0;
      oca  <= '0;
    end else begin
      if (pix) begin
        rx <= rx + TW'(1);
        if (WW'(wcol) + WW'(1) == w_sat) begin
          wcol <= '0;
          wcb  <= '0;
          wca  <= '0;
          wrb  <= (wrb == BW'(NB - 1)) ? '0 : wrb + BW'(1);
        end else begin
          wcol <= wcol + CW'(1);
          if (wcb == BW'(NB - 1)) begin
            wcb <= '0;
            wca <= wca + AW'(1);
          end else begin
            wcb <= wcb + BW'(1);
          end
        end
      end
      if (emit) begin
        em <= em + TW'(1);
        if (WW'(ocol) + WW'(1) == w_sat) begin
          ocol <= '0;
          ocb  <= '0;
          oca  <= '0;
          orow <= orow + RW'(1);
          orb  <= (orb == BW'(NB - 1)) ? '0 : orb + BW'(1);
        end else begin
          ocol <= ocol + CW'(1);
          if (ocb == BW'(NB - 1)) begin
            ocb <= '0;
            oca <= oca + AW'(1);
          end else begin
            ocb <= ocb + BW'(1);
          end
        end
      end
    end
  end

  // Output position of the emitted pixel, handed to the window read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else if (!s1.valid || en1) begin
      s1.valid <= emit;
      s1.last  <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      s1_row <= orow;
      s1_col <= ocol;
      s1_rb  <= orb;
      s1_cb  <= ocb;
      s1_ca  <= oca;
    end
  end
endmodule

// ===== rtl/rgbc_taps.sv =====
// Banked line store and the parallel read of a whole tap window.
module rgbc_taps #(
  parameter int MAX_WIDTH  = rgbc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rgbc_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_KERNEL = rgbc_pkg::DEF_MAX_KERNEL,
  localparam int NB = MAX_KERNEL,
  localparam int BD = (MAX_WIDTH + NB - 1) / NB,
  localparam int BW = rgbc_pkg::clog2m(NB),
  localparam int AW = rgbc_pkg::clog2m(BD),
  localparam int NW = $clog2(MAX_KERNEL + 1),
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1),
  localparam int CW = rgbc_pkg::clog2m(MAX_WIDTH),
  localparam int RW = rgbc_pkg::clog2m(MAX_HEIGHT)
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic [NW-1:0]                                  n_sat,
  input  logic [NW-1:0]                                  half,
  input  logic [WW-1:0]                                  w_sat,
  input  logic [HW-1:0]                                  h_sat,
  input  logic                                           wr_en,
  input  logic [BW-1:0]                                  wr_rb,
  input  logic [BW-1:0]                                  wr_cb,
  input  logic [AW-1:0]                                  wr_ca,
  input  logic [rgbc_pkg::PIXEL_W-1:0]                   wr_data,
  input  rgbc_pkg::stage_t                               s1,
  input  logic [RW-1:0]                                  s1_row,
  input  logic [CW-1:0]                                  s1_col,
  input  logic [BW-1:0]                                  s1_rb,
  input  logic [BW-1:0]                                  s1_cb,
  input  logic [AW-1:0]                                  s1_ca,
  input  logic                                           en2,
  output logic                                           en1,
  output rgbc_pkg::stage_t                               s2,
  output logic [NB*NB-1:0][rgbc_pkg::PIXEL_W-1:0]        tap
);
  import rgbc_pkg::*;

  logic [AW-1:0]      raddr [NB];
  logic [PIXEL_W-1:0] rd [NB][NB];
  logic [BW-1:0]      fb;
  logic [BW-1:0]      frb;
  logic [NB-1:0]      row_ok;
  logic [NB-1:0]      col_ok;
  logic [BW-1:0]      fb2;
  logic [BW-1:0]      frb2;
  logic [NB*NB-1:0]   mask2;

  assign en1 = !s2.valid || en2;

  // Window origin in bank form, one column address per column bank,
  // and which rows and columns of the window lie inside the image.
  always_comb begin
    int fb_i;
    int frb_i;
    int pos;
    logic [AW-1:0] fa;
    fa    = s1_ca;
    fb_i  = int'(s1_cb) - int'(half);
    frb_i = int'(s1_rb) - int'(half);
    if (fb_i < 0) begin
      fb_i = fb_i + NB;
      fa   = s1_ca - AW'(1);
    end
    if (frb_i < 0) begin
      frb_i = frb_i + NB;
    end
    fb  = BW'(fb_i);
    frb = BW'(frb_i);
    for (int q = 0; q < NB; q++) begin
      raddr[q] = (q < fb_i) ? fa + AW'(1) : fa;
    end
    for (int i = 0; i < NB; i++) begin
      pos       = int'(s1_row) + i - int'(half);
      row_ok[i] = (pos >= 0) && (pos < int'(h_sat)) && (i < int'(n_sat));
      pos       = int'(s1_col) + i - int'(half);
      col_ok[i] = (pos >= 0) && (pos < int'(w_sat)) && (i < int'(n_sat));
    end
  end

  // One RAM per row bank and column bank.
  for (genvar p = 0; p < NB; p++) begin : g_row
    for (genvar q = 0; q < NB; q++) begin : g_col
      rgbc_ram #(
        .WIDTH(PIXEL_W),
        .DEPTH(BD)
      ) u_ram (
        .clk  (clk),
        .we   (wr_en && wr_rb == BW'(p) && wr_cb == BW'(q)),
        .waddr(wr_ca),
        .wdata(wr_data),
        .re   (en1),
        .raddr(raddr[q]),
        .rdata(rd[p][q])
      );
    end
  end

  // Window placement travels alongside the read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2 <= '0;
    end else if (en1) begin
      s2 <= s1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      fb2  <= fb;
      frb2 <= frb;
      for (int i = 0; i < NB; i++) begin
        for (int j = 0; j < NB; j++) begin
          mask2[i*NB+j] <= row_ok[i] && col_ok[j];
        end
      end
    end
  end

  // Rotate bank outputs into tap order; taps outside the image or the kernel size are zero.
  always_comb begin
    int rb_i;
    int cb_i;
    for (int i = 0; i < NB; i++) begin
      for (int j = 0; j < NB; j++) begin
        rb_i = int'(frb2) + i;
        cb_i = int'(fb2) + j;
        if (rb_i >= NB) rb_i = rb_i - NB;
        if (cb_i >= NB) cb_i = cb_i - NB;
        tap[i*NB+j] = mask2[i*NB+j] ? rd[BW'(rb_i)][BW'(cb_i)] : '0;
      end
    end
  end
endmodule

// ===== rtl/rgbc_mac.sv =====
// Multiply, row sums, final sum with clamp, and the output register.
module rgbc_mac #(
  parameter int MAX_KERNEL     = rgbc_pkg::DEF_MAX_KERNEL,
  parameter int COEF_FRAC_BITS = rgbc_pkg::DEF_COEF_FRAC_BITS,
  localparam int NB = MAX_KERNEL
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  rgbc_pkg::kernel_t                         kernel,
  input  rgbc_pkg::stage_t                          s2,
  input  logic [NB*NB-1:0][rgbc_pkg::PIXEL_W-1:0]   tap,
  output logic                                      en2,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [rgbc_pkg::PIX_W-1:0]                out_red,
  output logic [rgbc_pkg::PIX_W-1:0]                out_green,
  output logic [rgbc_pkg::PIX_W-1:0]                out_blue,
  output logic                                      last_pixel
);
  import rgbc_pkg::*;

  localparam int RSW = PROD_W + clog2m(NB) + 1;
  localparam int SW  = RSW + clog2m(NB) + 1;

  stage_t s3;
  stage_t s4;
  logic   en3;
  logic   en4;

  logic signed [PROD_W-1:0] prod_next [COLORS][NB][NB];
  logic signed [PROD_W-1:0] prod      [COLORS][NB][NB];
  logic signed [RSW-1:0]    rsum_next [COLORS][NB];
  logic signed [RSW-1:0]    rsum      [COLORS][NB];
  logic [PIX_W-1:0]         fin       [COLORS];

  assign en4 = !out_valid || out_ready;
  assign en3 = !s4.valid || en4;
  assign en2 = !s3.valid || en3;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s3        <= '0;
      s4        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (en2) s3 <= s2;
      if (en3) s4 <= s3;
      if (en4) out_valid <= s4.valid;
    end
  end

  // One product per tap and color.
  always_comb begin
    logic signed [PROD_W-1:0] cf;
    logic signed [PROD_W-1:0] px;
    for (int c = 0; c < COLORS; c++) begin
      for (int i = 0; i < NB; i++) begin
        for (int j = 0; j < NB; j++) begin
          cf = PROD_W'(coef_at(kernel, i, j));
          px = PROD_W'({1'b0, tap[i*NB+j][PIX_W*(COLORS-1-c) +: PIX_W]});
          prod_next[c][i][j] = cf * px;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2) prod <= prod_next;
  end

  // Sum each kernel row.
  always_comb begin
    for (int c = 0; c < COLORS; c++) begin
      for (int i = 0; i < NB; i++) begin
        rsum_next[c][i] = '0;
        for (int j = 0; j < NB; j++) begin
          rsum_next[c][i] = rsum_next[c][i] + RSW'(prod[c][i][j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) rsum <= rsum_next;
  end

  // Total, truncate toward zero and clamp to the pixel range.
  always_comb begin
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] sh;
    for (int c = 0; c < COLORS; c++) begin
      s = '0;
      for (int i = 0; i < NB; i++) begin
        s = s + SW'(rsum[c][i]);
      end
      sh = s >>> COEF_FRAC_BITS;
      if (s <= 0) begin
        fin[c] = '0;
      end else if (sh > SW'(PIX_MAX)) begin
        fin[c] = PIX_MAX;
      end else begin
        fin[c] = sh[PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      out_red    <= fin[0];
      out_green  <= fin[1];
      out_blue   <= fin[2];
      last_pixel <= s4.last;
    end
  end
endmodule

// ===== rtl/rgb_image_convolution.sv =====
// Top level of the streaming NxN RGB convolution block.
//
//  channel  direction  handshake             payload
//  cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
//  in       in         in_valid/in_ready     red, green, blue, drain
//  out      out        out_valid/out_ready   out_red, out_green, out_blue, last_pixel
//
// One input transaction per cycle is sustained while neither the output stalls nor a
// configuration write holds the input off; the kernel window is read from MAX_KERNEL x
// MAX_KERNEL line-store banks in parallel, so no tap needs a second memory access. A
// result is registered through position, window read, multiply, row sum and output stages.
// Input is held off in the cycle after each configuration write.
// Reset is synchronous; the line store is not cleared and needs no clearing pass.
// A stalled output stage stalls only the stages behind it until a bubble is used up.
module rgb_image_convolution #(
  parameter int MAX_WIDTH      = rgbc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = rgbc_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_KERNEL     = rgbc_pkg::DEF_MAX_KERNEL,
  parameter int COEF_FRAC_BITS = rgbc_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rgbc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rgbc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rgbc_pkg::PIX_W-1:0]        red,
  input  logic [rgbc_pkg::PIX_W-1:0]        green,
  input  logic [rgbc_pkg::PIX_W-1:0]        blue,
  input  logic                              drain,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rgbc_pkg::PIX_W-1:0]        out_red,
  output logic [rgbc_pkg::PIX_W-1:0]        out_green,
  output logic [rgbc_pkg::PIX_W-1:0]        out_blue,
  output logic                              last_pixel
);
  import rgbc_pkg::*;

  localparam int NB = MAX_KERNEL;
  localparam int BW = clog2m(NB);
  localparam int AW = clog2m((MAX_WIDTH + NB - 1) / NB);
  localparam int NW = $clog2(MAX_KERNEL + 1);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = clog2m(MAX_WIDTH);
  localparam int RW = clog2m(MAX_HEIGHT);

  logic [NW-1:0]      n_sat;
  logic [NW-1:0]      half;
  logic [WW-1:0]      w_sat;
  logic [HW-1:0]      h_sat;
  kernel_t            kernel;
  logic               wr_en;
  logic [BW-1:0]      wr_rb;
  logic [BW-1:0]      wr_cb;
  logic [AW-1:0]      wr_ca;
  logic [PIXEL_W-1:0] wr_data;
  stage_t             s1;
  stage_t             s2;
  logic [RW-1:0]      s1_row;
  logic [CW-1:0]      s1_col;
  logic [BW-1:0]      s1_rb;
  logic [BW-1:0]      s1_cb;
  logic [AW-1:0]      s1_ca;
  logic               en1;
  logic               en2;
  logic [NB*NB-1:0][PIXEL_W-1:0] tap;

  rgbc_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_KERNEL(MAX_KERNEL)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .drain    (drain),
    .en1      (en1),
    .n_sat    (n_sat),
    .half     (half),
    .w_sat    (w_sat),
    .h_sat    (h_sat),
    .kernel   (kernel),
    .wr_en    (wr_en),
    .wr_rb    (wr_rb),
    .wr_cb    (wr_cb),
    .wr_ca    (wr_ca),
    .wr_data  (wr_data),
    .s1       (s1),
    .s1_row   (s1_row),
    .s1_col   (s1_col),
    .s1_rb    (s1_rb),
    .s1_cb    (s1_cb),
    .s1_ca    (s1_ca)
  );

  rgbc_taps #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_KERNEL(MAX_KERNEL)
  ) u_taps (
    .clk    (clk),
    .rst    (rst),
    .n_sat  (n_sat),
    .half   (half),
    .w_sat  (w_sat),
    .h_sat  (h_sat),
    .wr_en  (wr_en),
    .wr_rb  (wr_rb),
    .wr_cb  (wr_cb),
    .wr_ca  (wr_ca),
    .wr_data(wr_data),
    .s1     (s1),
    .s1_row (s1_row),
    .s1_col (s1_col),
    .s1_rb  (s1_rb),
    .s1_cb  (s1_cb),
    .s1_ca  (s1_ca),
    .en2    (en2),
    .en1    (en1),
    .s2     (s2),
    .tap    (tap)
  );

  rgbc_mac #(
    .MAX_KERNEL    (MAX_KERNEL),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .kernel    (kernel),
    .s2        (s2),
    .tap       (tap),
    .en2       (en2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .last_pixel(last_pixel)
  );
endmodule

// ===== rtl/rgbc_checker.sv =====
// Port-level checks for the RGB convolution block, bound to the top level.
module rgbc_checker (
  input logic       clk,
  input logic       rst,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic       last_pixel
);
  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green) &&
    $stable(out_blue) && $stable(last_pixel))
    else $error("result changed while stalled");

  // Reset empties the output stage.
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present right after reset");

  // The input is closed for the cycle after a configuration write.
  a_cfg_gap: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input open right after a configuration write");
endmodule

bind rgb_image_convolution rgbc_checker u_chk (.*);
